// ===== rtl/core/twcs_pkg.sv =====
package twcs_pkg;

	localparam int TEX_SIZE  = 64;
	localparam int TEX_COUNT = 4;
	localparam int MAX_ROWS  = 4096;

	localparam int TEX_W       = $clog2(TEX_SIZE);
	localparam int SLOT_W      = $clog2(TEX_COUNT);
	localparam int TEX_AREA_W  = 2 * TEX_W;
	localparam int STORE_DEPTH = TEX_COUNT * TEX_SIZE * TEX_SIZE;
	localparam int STORE_AW    = SLOT_W + TEX_AREA_W;

	// Q.16 step: TEX_SIZE << 16 needs TEX_W + 17 bits.
	localparam int FRAC_W  = 16;
	localparam int STEP_W  = TEX_W + FRAC_W + 1;
	localparam int POS_W   = 40;
	localparam int CNT_W   = $clog2(STEP_W);
	localparam int NUM_W   = 17;
	localparam int ROW_W   = 13;
	localparam int HGT_W   = 16;
	localparam int COLOR_W = 32;

	localparam logic [ROW_W-1:0] MAX_ROWS_V   = ROW_W'(MAX_ROWS);
	localparam logic [ROW_W-1:0] SCREEN_RESET = ROW_W'(480);

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_BEGIN = 2'd1,
		FUNC_ROW   = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_CEILING = 2'd0,
		REG_FLOOR   = 2'd1,
		REG_SCREEN  = 2'd2,
		REG_NONE    = 2'd3
	} reg_index_t;

endpackage

// ===== rtl/core/textured_wall_column_shader_unit.sv =====
// Channel  Direction  Handshake              Payload
// item     into unit  item_valid/item_stall  func, column, wall_start, wall_end, wall_height,
//                                            tex_column, side, texel_addr, texel_data
// pixel    out        pixel_valid/pixel_stall pixel_x, pixel_y, color, last
// config   into unit  cfg_we                 cfg_index, cfg_data
//
// A load writes the texel store as it transfers. A row reads the texel store, then loads
// the output register. A begin runs STEP_W restoring divide steps, one per cycle on a
// shared 17-bit subtractor, then the start position multiply.
// arst_n clears the sequencer, the column latches and the registers; the texel store
// is not cleared. A row result waits in the output register while pixel_stall is high.
module textured_wall_column_shader_unit
	import twcs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                item_valid,
	output logic                item_stall,
	input  logic [1:0]          func,
	input  logic [11:0]         column,
	input  logic [12:0]         wall_start,
	input  logic [12:0]         wall_end,
	input  logic [15:0]         wall_height,
	input  logic [5:0]          tex_column,
	input  logic [1:0]          side,
	input  logic [11:0]         texel_addr,
	input  logic [31:0]         texel_data,

	output logic                pixel_valid,
	input  logic                pixel_stall,
	output logic [11:0]         pixel_x,
	output logic [11:0]         pixel_y,
	output logic [31:0]         color,
	output logic                last,

	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_ROW
	} state_t;

	typedef enum logic [1:0] {
		KIND_CEILING,
		KIND_WALL,
		KIND_FLOOR
	} kind_t;

	state_t                state_q;
	kind_t                 kind_q;

	logic [COLOR_W-1:0]    ceiling_q;
	logic [COLOR_W-1:0]    floor_q;
	logic [ROW_W-1:0]      screen_q;

	logic [ROW_W-1:0]      cur_row_q;
	logic [11:0]           col_q;
	logic [ROW_W-1:0]      start_q;
	logic [ROW_W-1:0]      stop_q;
	logic [TEX_W-1:0]      texcol_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [STEP_W-1:0]     step_q;
	logic [POS_W-1:0]      tex_pos_q;

	logic [HGT_W-1:0]      divisor_q;
	logic [HGT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [NUM_W-1:0]      num2_q;
	logic                  num2_pos_q;

	logic [11:0]           row_y_q;
	logic                  row_last_q;

	logic [COLOR_W-1:0]    texel_store [STORE_DEPTH];
	logic [COLOR_W-1:0]    rd_q;

	logic                  item_xfer;
	logic                  load_xfer;
	logic                  begin_xfer;
	logic                  row_xfer;
	logic [ROW_W-1:0]      eff_h;
	logic [HGT_W-1:0]      h_eff;
	logic [18:0]           num2_sum;
	logic [HGT_W:0]        trial;
	logic                  trial_ge;
	logic [POS_W-1:0]      prod;
	logic [STORE_AW-1:0]   waddr;
	logic [STORE_AW-1:0]   raddr;
	logic [ROW_W-1:0]      next_row;
	logic                  out_free;

	assign item_stall = (state_q != ST_IDLE);
	assign item_xfer  = item_valid && !item_stall;
	assign load_xfer  = item_xfer && (func_t'(func) == FUNC_LOAD);
	assign begin_xfer = item_xfer && (func_t'(func) == FUNC_BEGIN);
	assign row_xfer   = item_xfer && (func_t'(func) == FUNC_ROW) && (cur_row_q < eff_h);

	assign eff_h    = (screen_q < MAX_ROWS_V) ? screen_q : MAX_ROWS_V;
	assign h_eff    = (wall_height == '0) ? HGT_W'(1) : wall_height;
	assign num2_sum = {5'b0, wall_start, 1'b0} + {3'b0, h_eff} - {6'b0, eff_h};

	// One restoring divide step: the dividend is 1 << (STEP_W-1), so its only set
	// bit enters on the first step.
	assign trial    = {rem_q, (cnt_q == '0)};
	assign trial_ge = (trial >= {1'b0, divisor_q});

	assign prod = {{(POS_W-NUM_W){1'b0}}, num2_q} * {{(POS_W-STEP_W){1'b0}}, step_q};

	assign waddr    = {side[SLOT_W-1:0], texel_addr[TEX_AREA_W-1:0]};
	assign raddr    = {slot_q, tex_pos_q[FRAC_W+TEX_W-1:FRAC_W], texcol_q};
	assign next_row = cur_row_q + ROW_W'(1);
	assign out_free = !pixel_valid || !pixel_stall;

	always_ff @(posedge clk) begin
		if (load_xfer) begin
			texel_store[waddr] <= texel_data;
		end
		if (row_xfer) begin
			rd_q <= texel_store[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= KIND_CEILING;
			ceiling_q   <= '0;
			floor_q     <= '0;
			screen_q    <= SCREEN_RESET;
			cur_row_q   <= '0;
			col_q       <= '0;
			start_q     <= '0;
			stop_q      <= '0;
			texcol_q    <= '0;
			slot_q      <= '0;
			step_q      <= '0;
			tex_pos_q   <= '0;
			divisor_q   <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			num2_q      <= '0;
			num2_pos_q  <= 1'b0;
			row_y_q     <= '0;
			row_last_q  <= 1'b0;
			pixel_valid <= 1'b0;
			pixel_x     <= '0;
			pixel_y     <= '0;
			color       <= '0;
			last        <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_index_t'(cfg_index))
					REG_CEILING: ceiling_q <= cfg_data;
					REG_FLOOR:   floor_q   <= cfg_data;
					REG_SCREEN:  screen_q  <= cfg_data[ROW_W-1:0];
					default: ;
				endcase
			end

			// In ST_ROW the output register is reloaded below instead.
			if (pixel_valid && !pixel_stall && (state_q != ST_ROW)) begin
				pixel_valid <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (begin_xfer) begin
						col_q      <= column;
						start_q    <= wall_start;
						stop_q     <= (wall_end > wall_start) ? wall_end : wall_start;
						texcol_q   <= tex_column[TEX_W-1:0];
						slot_q     <= {side[1], side[1] ^ side[0]};
						cur_row_q  <= '0;
						divisor_q  <= h_eff;
						rem_q      <= '0;
						cnt_q      <= '0;
						step_q     <= '0;
						num2_q     <= num2_sum[NUM_W-1:0];
						num2_pos_q <= !num2_sum[18] && (num2_sum != '0);
						state_q    <= ST_DIV;
					end else if (row_xfer) begin
						row_y_q    <= cur_row_q[11:0];
						row_last_q <= (next_row == eff_h);
						cur_row_q  <= next_row;
						if (cur_row_q < start_q) begin
							kind_q <= KIND_CEILING;
						end else if (cur_row_q >= stop_q) begin
							kind_q <= KIND_FLOOR;
						end else begin
							kind_q    <= KIND_WALL;
							tex_pos_q <= tex_pos_q + {{(POS_W-STEP_W){1'b0}}, step_q};
						end
						state_q <= ST_ROW;
					end
				end
				ST_DIV: begin
					rem_q  <= trial_ge ? HGT_W'(trial - {1'b0, divisor_q}) : trial[HGT_W-1:0];
					step_q <= {step_q[STEP_W-2:0], trial_ge};
					cnt_q  <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(STEP_W - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// The start position is half the product; when twice the start plus the wall height
					// is below the screen height the value is negative, and it is clamped to zero.
					tex_pos_q <= num2_pos_q ? {1'b0, prod[POS_W-1:1]} : '0;
					state_q   <= ST_IDLE;
				end
				ST_ROW: begin
					if (out_free) begin
						pixel_valid <= 1'b1;
						pixel_x     <= col_q;
						pixel_y     <= row_y_q;
						last        <= row_last_q;
						unique case (kind_q)
							KIND_CEILING: color <= ceiling_q;
							KIND_FLOOR:   color <= floor_q;
							default:      color <= rd_q;
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== test/tb_textured_wall_column_shader_unit.sv =====
module tb_textured_wall_column_shader_unit
	import twcs_pkg::*;
();

	localparam int CLK_PERIOD     = 10;
	localparam int TIMEOUT_CYCLES = 1_000_000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;

	localparam logic [1:0] SIDE_NORTH = 2'd0;
	localparam logic [1:0] SIDE_SOUTH = 2'd1;
	localparam logic [1:0] SIDE_EAST  = 2'd2;
	localparam logic [1:0] SIDE_WEST  = 2'd3;

	typedef struct packed {
		func_t       op;
		logic [11:0] column;
		logic [12:0] wall_start;
		logic [12:0] wall_end;
		logic [15:0] wall_height;
		logic [5:0]  tex_column;
		logic [1:0]  side;
		logic [11:0] texel_addr;
		logic [31:0] texel_data;
	} shade_item_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [31:0] color;
		logic        last;
	} pixel_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        item_valid = 1'b0;
	logic        item_stall;
	shade_item_t offered    = '0;
	shade_item_t next_item;

	logic        pixel_valid;
	logic        pixel_stall = 1'b0;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [31:0] color;
	logic        last;

	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data  = '0;

	// Own copy of the shader state, updated at each accepted item transfer and register write.
	logic [31:0]       texels [STORE_DEPTH];
	logic [31:0]       cfg_ceiling = '0;
	logic [31:0]       cfg_floor   = '0;
	logic [ROW_W-1:0]  cfg_screen  = SCREEN_RESET;
	logic [ROW_W-1:0]  pr_row      = '0;
	logic [11:0]       pr_col      = '0;
	logic [ROW_W-1:0]  pr_start    = '0;
	logic [ROW_W-1:0]  pr_end      = '0;
	logic [TEX_W-1:0]  pr_texcol   = '0;
	logic [SLOT_W-1:0] pr_slot     = '0;
	logic [STEP_W-1:0] pr_step     = '0;
	logic [POS_W-1:0]  pr_pos      = '0;

	shade_item_t pending_items[$];
	pixel_t      due_pixels[$];
	pixel_t      want;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_tag       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	int bad_count = 0;
	int n_checked = 0;
	int n_load    = 0;
	int n_begin   = 0;
	int n_row     = 0;
	int n_skip    = 0;
	int n_writes  = 0;

	textured_wall_column_shader_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.func        (offered.op),
		.column      (offered.column),
		.wall_start  (offered.wall_start),
		.wall_end    (offered.wall_end),
		.wall_height (offered.wall_height),
		.tex_column  (offered.tex_column),
		.side        (offered.side),
		.texel_addr  (offered.texel_addr),
		.texel_data  (offered.texel_data),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color       (color),
		.last        (last),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [ROW_W-1:0] eff_rows();
		return (cfg_screen > MAX_ROWS_V) ? MAX_ROWS_V : cfg_screen;
	endfunction

	// Each texture slot is only ever read at one texture column, so only that
	// column of each slot needs loading before wall rows are shaded.
	function automatic logic [5:0] slot_col(input logic [1:0] slot);
		return {slot, slot, slot};
	endfunction

	function automatic logic [5:0] side_col(input logic [1:0] sd);
		return slot_col(sd ^ (sd >> 1));
	endfunction

	task automatic shade_accept(input shade_item_t it);
		logic [16:0]      h;
		logic [ROW_W-1:0] hgt;
		logic [ROW_W-1:0] wall_stop;
		longint           num2;
		logic [63:0]      prod;
		pixel_t           px;
		case (it.op)
			FUNC_LOAD: begin
				texels[{it.side, it.texel_addr}] = it.texel_data;
				n_load++;
			end
			FUNC_BEGIN: begin
				h = (it.wall_height == '0) ? 17'd1 : {1'b0, it.wall_height};
				pr_col    = it.column;
				pr_start  = it.wall_start;
				pr_end    = it.wall_end;
				pr_texcol = it.tex_column;
				// East and west hit sides use each other's texture slot.
				pr_slot   = it.side ^ (it.side >> 1);
				pr_step   = STEP_W'((64'(TEX_SIZE) << FRAC_W) / 64'(h));
				num2 = 2 * longint'(it.wall_start) - longint'(eff_rows()) + longint'(h);
				prod = (num2 > 0) ? ((64'(num2) * 64'(pr_step)) >> 1) : 64'd0;
				pr_pos = prod[POS_W-1:0];
				pr_row = '0;
				n_begin++;
			end
			FUNC_ROW: begin
				hgt = eff_rows();
				n_row++;
				if (pr_row < hgt) begin
					wall_stop = (pr_end > pr_start) ? pr_end : pr_start;
					if (pr_row < pr_start) begin
						px.color = cfg_ceiling;
					end else if (pr_row >= wall_stop) begin
						px.color = cfg_floor;
					end else begin
						px.color = texels[{pr_slot, pr_pos[FRAC_W +: TEX_W], pr_texcol}];
						pr_pos = pr_pos + POS_W'(pr_step);
					end
					px.x    = pr_col;
					px.y    = pr_row[11:0];
					px.last = (pr_row + ROW_W'(1) == hgt);
					due_pixels.push_back(px);
					pr_row = pr_row + ROW_W'(1);
				end
			end
			default: n_skip++;
		endcase
	endtask

	// Item driver: a new item is presented only once the previous one has transferred.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall)
				shade_accept(offered);
			if (!item_valid || !item_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_item = pending_items.pop_front();
					offered <= next_item;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_tag) begin
			hold_seen <= hold_tag;
			hold_left <= HOLD_CYCLES;
			pixel_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			pixel_stall <= 1'b1;
		end else begin
			pixel_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && pixel_valid && !pixel_stall) begin
			if (due_pixels.size() == 0) begin
				bad_count++;
				if (bad_count <= MAX_REPORTS)
					$display("unexpected pixel: x=%0d y=%0d color=%h last=%0d",
						pixel_x, pixel_y, color, last);
			end else begin
				want = due_pixels.pop_front();
				n_checked++;
				if (want.x !== pixel_x || want.y !== pixel_y || want.color !== color ||
						want.last !== last) begin
					bad_count++;
					if (bad_count <= MAX_REPORTS) begin
						$display("pixel mismatch: expected x=%0d y=%0d color=%h last=%0d",
							want.x, want.y, want.color, want.last);
						$display("                got      x=%0d y=%0d color=%h last=%0d",
							pixel_x, pixel_y, color, last);
					end
				end
			end
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		n_writes++;
		case (idx)
			REG_CEILING: cfg_ceiling = val;
			REG_FLOOR:   cfg_floor = val;
			REG_SCREEN:  cfg_screen = val[ROW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [31:0] ceil_c, input logic [31:0] floor_c,
			input logic [ROW_W-1:0] rows);
		write_reg(REG_CEILING, ceil_c);
		write_reg(REG_FLOOR, floor_c);
		// Bits above the register width carry noise.
		write_reg(REG_SCREEN, ($urandom() & ~32'h1FFF) | 32'(rows));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every item has transferred and every pixel has come back,
	// then gives the block time to finish a column start that has no pixel.
	// The check runs on the falling edge, after the driver's updates have landed.
	task automatic settle();
		while (pending_items.size() != 0 || item_valid || due_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic shade_item_t noise_item(input func_t op);
		shade_item_t it;
		it.op          = op;
		it.column      = 12'($urandom());
		it.wall_start  = 13'($urandom());
		it.wall_end    = 13'($urandom());
		it.wall_height = 16'($urandom());
		it.tex_column  = 6'($urandom());
		it.side        = 2'($urandom());
		it.texel_addr  = 12'($urandom());
		it.texel_data  = $urandom();
		return it;
	endfunction

	task automatic add_load(input logic [1:0] slot, input logic [11:0] addr,
			input logic [31:0] data);
		shade_item_t it;
		it = noise_item(FUNC_LOAD);
		it.side = slot;
		it.texel_addr = addr;
		it.texel_data = data;
		pending_items.push_back(it);
	endtask

	task automatic add_column(input logic [11:0] col, input logic [12:0] ws,
			input logic [12:0] we, input logic [15:0] ht, input logic [5:0] tc,
			input logic [1:0] sd, input int rows);
		shade_item_t it;
		it = noise_item(FUNC_BEGIN);
		it.column = col;
		it.wall_start = ws;
		it.wall_end = we;
		it.wall_height = ht;
		it.tex_column = tc;
		it.side = sd;
		pending_items.push_back(it);
		repeat (rows) pending_items.push_back(noise_item(FUNC_ROW));
	endtask

	// Mostly whole columns with random geometry, plus stray loads and unused codes.
	task automatic random_phase(input int n_items, input int pause_at);
		int         done_items;
		int         h;
		int         ws;
		int         we;
		int         ht;
		int         rows;
		int         pick;
		bit         paused;
		logic [1:0] sd;
		done_items = 0;
		paused = 1'b0;
		h = int'(eff_rows());
		while (done_items < n_items) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				pending_items.push_back(noise_item(FUNC_LOAD));
				done_items++;
			end else if (pick < 14) begin
				pending_items.push_back(noise_item(FUNC_NONE));
			end else begin
				case ($urandom_range(9))
					0: ws = 0;
					1: ws = h;
					2: ws = $urandom_range(0, 8191);
					default: ws = $urandom_range(0, h);
				endcase
				case ($urandom_range(9))
					0, 1: we = $urandom_range(0, ws);
					2: we = $urandom_range(0, 8191);
					default: we = $urandom_range(ws, h + 1);
				endcase
				case ($urandom_range(9))
					0: ht = 0;
					1: ht = $urandom_range(0, 65535);
					2: ht = 65535;
					3, 4: ht = $urandom_range(1, 8);
					default: ht = $urandom_range(1, 3 * h + 4);
				endcase
				if ($urandom_range(9) < 7)
					rows = h + $urandom_range(0, 2);
				else
					rows = $urandom_range(0, h);
				sd = 2'($urandom_range(0, 3));
				add_column(12'($urandom_range(0, 4095)), 13'(ws), 13'(we), 16'(ht),
					side_col(sd), sd, rows);
				done_items += rows + 1;
			end
			if (pause_at > 0 && !paused && done_items >= pause_at) begin
				paused = 1'b1;
				settle();
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Every texel that a wall row can read is written first.
		write_reg(REG_NONE, $urandom());
		set_regs($urandom(), $urandom(), 13'd6);
		for (int s = 0; s < TEX_COUNT; s++)
			for (int r = 0; r < TEX_SIZE; r++)
				add_load(2'(s), {6'(r), slot_col(2'(s))}, $urandom());

		add_load(2'd3, 12'hFFF, 32'hFFFF_FFFF);
		add_load(2'd0, 12'h000, 32'h0000_0000);
		add_column(12'd17, 13'd1, 13'd5, 16'd4, side_col(SIDE_EAST), SIDE_EAST, 7);
		// Start position goes negative and is clamped.
		add_column(12'd0, 13'd0, 13'd6, 16'd1, side_col(SIDE_WEST), SIDE_WEST, 3);
		// Zero height, and a wall end above the start leaves no wall rows.
		add_column(12'd300, 13'd4, 13'd2, 16'd0, 6'd5, SIDE_NORTH, 6);
		add_column(12'd4095, 13'd8191, 13'd8191, 16'd65535, 6'd31, SIDE_SOUTH, 2);
		pending_items.push_back(noise_item(FUNC_NONE));
		settle();

		// A tall wall on a full-size screen starts partway into its texture.
		set_regs(32'hFFFF_FFFF, 32'h0000_0000, 13'd4096);
		add_column(12'($urandom()), 13'd2, 13'd3000, 16'd65535, side_col(SIDE_NORTH),
			SIDE_NORTH, 8);
		settle();
		set_regs(32'h0000_0000, 32'hFFFF_FFFF, 13'd8191);
		add_column(12'($urandom()), 13'd2, 13'd5, 16'd3, side_col(SIDE_SOUTH),
			SIDE_SOUTH, 8);
		settle();

		// Long receiver hold while the sender keeps offering rows.
		set_regs($urandom(), $urandom(), 13'($urandom_range(2, 16)));
		hold_tag++;
		random_phase(40, 0);
		settle();

		send_idle_pct = 69;
		set_regs($urandom(), $urandom(), 13'd1);
		random_phase(40, 20);
		settle();

		send_idle_pct = 0;
		recv_stall_pct = 69;
		set_regs($urandom(), $urandom(), 13'($urandom_range(2, 16)));
		random_phase(40, 0);
		settle();

		// A zero screen height shades nothing.
		send_idle_pct = 18;
		recv_stall_pct = 18;
		set_regs($urandom(), $urandom(), 13'd0);
		random_phase(16, 0);
		settle();

		set_regs($urandom(), $urandom(), 13'($urandom_range(2, 16)));
		random_phase(40, 0);
		settle();

		send_idle_pct = 69;
		recv_stall_pct = 0;
		set_regs($urandom(), $urandom(), 13'($urandom_range(2, 16)));
		random_phase(30, 0);
		settle();

		$display("Run covered %0d column starts, %0d row steps, %0d texel loads, %0d unused codes.",
			n_begin, n_row, n_load, n_skip);
		$display("%0d pixels compared over %0d register writes; %0d mismatches.",
			n_checked, n_writes, bad_count);
		if (bad_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("TB_ERROR");
		$finish;
	end

endmodule
